// ----- rtl/plp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the permission list parser.
// Used by every module of the block; depends on nothing.
package plp_pkg;

   localparam int unsigned MAX_ENTRIES = 65535;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_IDX_W = $clog2(QUEUE_DEPTH);

   localparam logic [15:0] CAPACITY_RESET    = 16'hFFFF;
   localparam logic        COUNT_ONLY_RESET  = 1'b0;
   localparam logic [15:0] DOMAIN_MASK_RESET = 16'hFFFF;

   localparam logic [7:0] CHAR_NUL  = 8'h00;
   localparam logic [7:0] CHAR_W    = 8'h77;
   localparam logic [7:0] CHAR_R    = 8'h72;
   localparam logic [7:0] CHAR_B    = 8'h62;
   localparam logic [7:0] CHAR_N    = 8'h6E;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   localparam logic [16:0] ACCUM_SAT = 17'h10000;

   typedef enum logic [1:0] {
      CSR_CAPACITY    = 2'd0,
      CSR_COUNT_ONLY  = 2'd1,
      CSR_DOMAIN_MASK = 2'd2,
      CSR_UNUSED      = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_PROTOCOL  = 2'd1,
      ST_NO_SPACE  = 2'd2,
      ST_BAD_PERM  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PERM_NONE  = 2'd0,
      PERM_READ  = 2'd1,
      PERM_WRITE = 2'd2,
      PERM_BOTH  = 2'd3
   } perm_type;

   typedef enum logic {
      KIND_ENTRY  = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   typedef struct packed {
      logic [15:0] capacity;
      logic        count_only;
      logic [15:0] domain_mask;
   } cfg_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] domain;
      perm_type    permission;
      status_type  status;
      logic [15:0] entry_count;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage

// ----- rtl/plp_parse.sv -----
`timescale 1ns / 1ps
// Per-byte entry parser: holds the entry and buffer state and forms up to
// two results for each accepted item. Depends on plp_pkg.
module plp_parse
   import plp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] byte_in,
   input  logic       end_of_buffer,
   input  logic       empty_buffer,
   input  cfg_type    cfg,
   output push_type   push
);

   logic [1:0]  len_ff,    len_in;
   logic        lvalid_ff, lvalid_in;
   perm_type    perm_ff,   perm_in;
   logic [16:0] accum_ff,  accum_in;
   logic        fault_ff,  fault_in;
   logic [15:0] seen_ff,   seen_in;
   status_type  err_ff,    err_in;

   logic [19:0] accum_mul;
   logic        is_digit;
   logic        cap_full;
   logic        mask_bad;
   logic        entry_ok;
   rsp_type     entry_rsp;
   rsp_type     status_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff    <= 2'd0;
         lvalid_ff <= 1'b0;
         perm_ff   <= PERM_NONE;
         accum_ff  <= 17'd0;
         fault_ff  <= 1'b0;
         seen_ff   <= 16'd0;
         err_ff    <= ST_OK;
      end else if (accept) begin
         len_ff    <= len_in;
         lvalid_ff <= lvalid_in;
         perm_ff   <= perm_in;
         accum_ff  <= accum_in;
         fault_ff  <= fault_in;
         seen_ff   <= seen_in;
         err_ff    <= err_in;
      end
   end

   assign is_digit  = (byte_in >= CHAR_ZERO) && (byte_in <= CHAR_NINE);
   assign accum_mul = {3'd0, accum_ff} * 20'd10 + {16'd0, byte_in[3:0]};
   assign cap_full  = (!cfg.count_only && (seen_ff >= cfg.capacity))
                      || ({16'd0, seen_ff} >= 32'(MAX_ENTRIES));
   assign mask_bad  = accum_ff[16] || ((accum_ff[15:0] & ~cfg.domain_mask) != 16'd0);

   always_comb begin
      len_in    = len_ff;
      lvalid_in = lvalid_ff;
      perm_in   = perm_ff;
      accum_in  = accum_ff;
      fault_in  = fault_ff;
      seen_in   = seen_ff;
      err_in    = err_ff;
      entry_ok  = 1'b0;

      if (empty_buffer) begin
         if (err_ff == ST_OK && len_ff != 2'd0) begin
            err_in = ST_PROTOCOL;
         end
      end else if (err_ff == ST_OK) begin
         if (byte_in == CHAR_NUL) begin
            if (len_ff < 2'd2) begin
               err_in = ST_PROTOCOL;
            end else if (cap_full) begin
               err_in = ST_NO_SPACE;
            end else if (!lvalid_ff) begin
               err_in = ST_BAD_PERM;
            end else if (fault_ff || mask_bad) begin
               err_in = ST_PROTOCOL;
            end else begin
               seen_in  = seen_ff + 16'd1;
               entry_ok = !cfg.count_only;
            end
            len_in    = 2'd0;
            lvalid_in = 1'b0;
            perm_in   = PERM_NONE;
            accum_in  = 17'd0;
            fault_in  = 1'b0;
         end else begin
            if (len_ff == 2'd0) begin
               case (byte_in)
                  CHAR_W: begin
                     lvalid_in = 1'b1;
                     perm_in   = PERM_WRITE;
                  end
                  CHAR_R: begin
                     lvalid_in = 1'b1;
                     perm_in   = PERM_READ;
                  end
                  CHAR_B: begin
                     lvalid_in = 1'b1;
                     perm_in   = PERM_BOTH;
                  end
                  CHAR_N: begin
                     lvalid_in = 1'b1;
                     perm_in   = PERM_NONE;
                  end
                  default: begin
                     lvalid_in = 1'b0;
                     perm_in   = PERM_NONE;
                  end
               endcase
            end else if (is_digit) begin
               accum_in = (accum_mul > {3'd0, ACCUM_SAT}) ? ACCUM_SAT : accum_mul[16:0];
            end else begin
               fault_in = 1'b1;
            end
            if (len_ff < 2'd2) begin
               len_in = len_ff + 2'd1;
            end
            if (end_of_buffer) begin
               err_in = ST_PROTOCOL;
            end
         end
      end

      entry_rsp.kind        = KIND_ENTRY;
      entry_rsp.domain      = accum_ff[15:0];
      entry_rsp.permission  = perm_ff;
      entry_rsp.status      = ST_OK;
      entry_rsp.entry_count = seen_in;
      entry_rsp.last        = 1'b0;

      status_rsp.kind        = KIND_STATUS;
      status_rsp.domain      = 16'd0;
      status_rsp.permission  = PERM_NONE;
      status_rsp.status      = err_in;
      status_rsp.entry_count = seen_in;
      status_rsp.last        = 1'b1;

      push.first  = entry_ok ? entry_rsp : status_rsp;
      push.second = status_rsp;
      push.count  = 2'd0;
      if (accept) begin
         push.count = {1'b0, entry_ok} + {1'b0, end_of_buffer || empty_buffer};
      end

      if (end_of_buffer || empty_buffer) begin
         len_in    = 2'd0;
         lvalid_in = 1'b0;
         perm_in   = PERM_NONE;
         accum_in  = 17'd0;
         fault_in  = 1'b0;
         seen_in   = 16'd0;
         err_in    = ST_OK;
      end
   end

endmodule

// ----- rtl/plp_queue.sv -----
`timescale 1ns / 1ps
// Result queue that takes up to two results per cycle and hands out one while out_ready is high.
// Depends on plp_pkg.
module plp_queue
   import plp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     has_room,
   output logic     out_valid,
   input  logic     out_ready,
   output rsp_type  out_data
);

   rsp_type                  mem_ff [QUEUE_DEPTH];
   logic [QUEUE_IDX_W-1:0]   head_ff, head_in;
   logic [QUEUE_IDX_W-1:0]   tail_ff, tail_in;
   logic [QUEUE_IDX_W:0]     cnt_ff,  cnt_in;
   logic                     pop;

   assign out_valid = (cnt_ff != '0);
   assign out_data  = mem_ff[head_ff];
   assign has_room  = (cnt_ff <= (QUEUE_IDX_W+1)'(QUEUE_DEPTH - 2));
   assign pop       = out_valid && out_ready;

   always_comb begin
      head_in = pop ? head_ff + 1'b1 : head_ff;
      tail_in = tail_ff + QUEUE_IDX_W'(push.count);
      cnt_in  = cnt_ff + (QUEUE_IDX_W+1)'(push.count) - (QUEUE_IDX_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[tail_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[tail_ff + 1'b1] <= push.second;
      end
   end

endmodule

// ----- rtl/permission_list_parser_core.sv -----
`timescale 1ns / 1ps
// Top level of the permission list parser: configuration registers, the
// per-byte parser and the result queue. Depends on plp_pkg, plp_parse, plp_queue.
//
// The req_ channel carries one buffer byte per item; req_tlast marks the last
// byte of a buffer and req_tuser marks a zero-length buffer, whose byte is ignored.
// Each valid NUL-terminated entry (permission letter and decimal domain) gives one
// entry result on the rsp_ channel (rsp_tuser low) unless count_only is set; the
// end of a buffer gives a status result (rsp_tuser high, rsp_tlast high) with the
// accepted entry count. The first bad entry stops entry results until the buffer
// ends. Results are queued and appear on rsp_ in order. The parser takes one item
// per clock while req_tready is high; an item that ends an entry and the buffer
// together yields two results, which the single-result output hands out one at a
// time. A four-deep result queue parts the two sides: req_tready stays high while
// the queue holds two results or fewer, so a stalled receiver stops input only
// once the queue holds more than two. The csr_ port writes capacity, count_only
// and domain_mask; write it only while the block is idle. Reset clears parser state
// and the queue and loads capacity 65535, count_only 0 and domain_mask 65535.
module permission_list_parser_core
   import plp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] byte_in
   input  logic        req_tlast,  // end_of_buffer
   input  logic        req_tuser,  // [0] empty_buffer
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // [15:0] domain, [17:16] permission,
                                   // [19:18] status, [35:20] entry_count, zero above
   output logic        rsp_tlast,  // last
   output logic        rsp_tuser,  // [0] kind
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   cfg_type  cfg_ff;
   push_type push;
   rsp_type  rsp;
   logic     has_room;
   logic     accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.capacity    <= CAPACITY_RESET;
         cfg_ff.count_only  <= COUNT_ONLY_RESET;
         cfg_ff.domain_mask <= DOMAIN_MASK_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_CAPACITY:    cfg_ff.capacity    <= csr_wdata;
            CSR_COUNT_ONLY:  cfg_ff.count_only  <= csr_wdata[0];
            CSR_DOMAIN_MASK: cfg_ff.domain_mask <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign req_tready = has_room;
   assign accept     = req_tvalid && has_room;

   plp_parse u_parse (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .byte_in       (req_tdata),
      .end_of_buffer (req_tlast),
      .empty_buffer  (req_tuser),
      .cfg           (cfg_ff),
      .push          (push)
   );

   plp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .has_room  (has_room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp)
   );

   assign rsp_tdata = {4'd0, rsp.entry_count, rsp.status, rsp.permission, rsp.domain};
   assign rsp_tlast = rsp.last;
   assign rsp_tuser = rsp.kind;

endmodule
